>>> hdl/yqrgb_pkg.sv
// Types and constants shared by the YCbCr 4:2:0 quad to RGB converter.
`default_nettype none

package yqrgb_pkg;

   localparam int unsigned LaneCount = 4;
   localparam int unsigned TermWidth = 26;
   localparam int unsigned FracBits  = 16;

   // BT.709 full-range coefficients in signed 10.16 fixed point.
   localparam logic signed [TermWidth-1:0] CoefRCr = 26'sd103206;
   localparam logic signed [TermWidth-1:0] CoefGCb = -26'sd12276;
   localparam logic signed [TermWidth-1:0] CoefGCr = -26'sd30679;
   localparam logic signed [TermWidth-1:0] CoefBCb = 26'sd121608;
   localparam logic signed [8:0]           ChromaMid = 9'sd128;

   typedef struct packed {
      logic [7:0] y_tl;
      logic [7:0] y_tr;
      logic [7:0] y_bl;
      logic [7:0] y_br;
      logic [7:0] cb;
      logic [7:0] cr;
   } req_type;

   typedef struct packed {
      logic [7:0] r_tl;
      logic [7:0] g_tl;
      logic [7:0] b_tl;
      logic [7:0] r_tr;
      logic [7:0] g_tr;
      logic [7:0] b_tr;
      logic [7:0] r_bl;
      logic [7:0] g_bl;
      logic [7:0] b_bl;
      logic [7:0] r_br;
      logic [7:0] g_br;
      logic [7:0] b_br;
   } rsp_type;

   typedef struct packed {
      logic signed [TermWidth-1:0] add_r;
      logic signed [TermWidth-1:0] add_g;
      logic signed [TermWidth-1:0] add_b;
   } chroma_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } pix_type;

endpackage

`default_nettype wire

>>> hdl/yqrgb_chroma.sv
// Shared chroma stage: scaled colour-difference terms for one quad, registered.
`default_nettype none

module yqrgb_chroma (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic [7:0]            cb,
   input  wire logic [7:0]            cr,
   output      yqrgb_pkg::chroma_type terms
);

   logic signed [8:0]     cbv;
   logic signed [8:0]     crv;
   yqrgb_pkg::chroma_type terms_in;
   yqrgb_pkg::chroma_type terms_ff;

   always_comb begin
      cbv = $signed({1'b0, cb}) - yqrgb_pkg::ChromaMid;
      crv = $signed({1'b0, cr}) - yqrgb_pkg::ChromaMid;
      terms_in.add_r = yqrgb_pkg::TermWidth'(crv) * yqrgb_pkg::CoefRCr;
      terms_in.add_g = yqrgb_pkg::TermWidth'(cbv) * yqrgb_pkg::CoefGCb
                     + yqrgb_pkg::TermWidth'(crv) * yqrgb_pkg::CoefGCr;
      terms_in.add_b = yqrgb_pkg::TermWidth'(cbv) * yqrgb_pkg::CoefBCb;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;

endmodule

`default_nettype wire

>>> hdl/yqrgb_lane.sv
// One pixel lane: adds the chroma terms to luma, floors and clamps to 0..255.
`default_nettype none

module yqrgb_lane (
   input  wire logic [7:0]            y,
   input  wire yqrgb_pkg::chroma_type terms,
   output      yqrgb_pkg::pix_type    pix
);

   function automatic logic [7:0] clamp_add(
      input logic [7:0]                            luma,
      input logic signed [yqrgb_pkg::TermWidth-1:0] term
   );
      logic signed [9:0]  whole;
      logic signed [10:0] sum;
      // Luma carries no fraction, so only the integer part of the term matters.
      whole = $signed(term[yqrgb_pkg::TermWidth-1:yqrgb_pkg::FracBits]);
      sum   = $signed({3'b000, luma}) + $signed({whole[9], whole});
      if (sum[10]) begin
         return 8'd0;
      end else if (sum[9:8] != 2'b00) begin
         return 8'd255;
      end else begin
         return sum[7:0];
      end
   endfunction

   always_comb begin
      pix.r = clamp_add(y, terms.add_r);
      pix.g = clamp_add(y, terms.add_g);
      pix.b = clamp_add(y, terms.add_b);
   end

endmodule

`default_nettype wire

>>> hdl/yuv420_quad_to_rgb.sv
// Top level of the BT.709 full-range YCbCr 4:2:0 quad to RGB converter.
//
// Each request transaction carries one 2x2 quad: four luma bytes and the
// shared Cb and Cr bytes. Each response transaction carries R, G and B for
// the four pixels, in the same order as the requests.
// The pipeline has two stages: the first registers the shared chroma terms
// and the lumas, the second runs four pixel lanes side by side and registers
// the packed result. A quad in the first stage moves into the output register
// as soon as that register is free, and rsp_valid rises with it.
// Throughput is one quad per clock while the receiver keeps rsp_ready high;
// the chroma multipliers and the lane adders each sit in a stage of their own.
// When the receiver holds rsp_ready low the result stays in the output
// register and the first stage keeps accepting until it is full too, after
// which req_ready falls. A synchronous reset empties both stages.
`default_nettype none

module yuv420_quad_to_rgb (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire yqrgb_pkg::req_type req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      yqrgb_pkg::rsp_type rsp_data
);

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic                  s1_load;
   logic [7:0]            luma_ff [yqrgb_pkg::LaneCount];
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  s2_ready;
   yqrgb_pkg::rsp_type    rsp_data_ff;
   yqrgb_pkg::rsp_type    rsp_data_in;
   yqrgb_pkg::chroma_type terms;
   yqrgb_pkg::pix_type    pix [yqrgb_pkg::LaneCount];

   assign s2_ready  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s2_ready;
   assign s1_load   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         luma_ff[0] <= req_data.y_tl;
         luma_ff[1] <= req_data.y_tr;
         luma_ff[2] <= req_data.y_bl;
         luma_ff[3] <= req_data.y_br;
      end
   end

   yqrgb_chroma u_chroma (
      .clock (clock),
      .load  (s1_load),
      .cb    (req_data.cb),
      .cr    (req_data.cr),
      .terms (terms)
   );

   for (genvar lane = 0; lane < yqrgb_pkg::LaneCount; lane++) begin : g_lane
      yqrgb_lane u_lane (
         .y     (luma_ff[lane]),
         .terms (terms),
         .pix   (pix[lane])
      );
   end

   // Merge the four lanes into the response layout.
   always_comb begin
      rsp_data_in.r_tl = pix[0].r;
      rsp_data_in.g_tl = pix[0].g;
      rsp_data_in.b_tl = pix[0].b;
      rsp_data_in.r_tr = pix[1].r;
      rsp_data_in.g_tr = pix[1].g;
      rsp_data_in.b_tr = pix[1].b;
      rsp_data_in.r_bl = pix[2].r;
      rsp_data_in.g_bl = pix[2].g;
      rsp_data_in.b_bl = pix[2].b;
      rsp_data_in.r_br = pix[3].r;
      rsp_data_in.g_br = pix[3].g;
      rsp_data_in.b_br = pix[3].b;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the BT.709 YCbCr 4:2:0 quad to RGB converter.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ClockHalf   = 4;
   localparam int unsigned ResetCycles = 8;
   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned RandomQuads = 1532;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned PrintCap    = 40;

   localparam int LumaScale  = 65536;
   localparam int RedCr      = 103206;
   localparam int GreenCb    = -12276;
   localparam int GreenCr    = -30679;
   localparam int BlueCb     = 121608;
   localparam int ChromaBias = 128;
   localparam int ScaleShift = 16;

   typedef enum logic [1:0] {
      RxFree,
      RxCoin,
      RxLongStall,
      RxQuarter
   } rx_mode_type;

   typedef enum logic [1:0] {
      MixUniform,
      MixUniformToo,
      MixChromaEdge,
      MixLumaEdge
   } quad_mix_type;

   class quad_scoreboard_type;
      yqrgb_pkg::rsp_type expected_rgb[$];
      string              field_tag [12];
      int unsigned        errors;
      int unsigned        checked;
      int unsigned        clamped_low;
      int unsigned        clamped_high;

      function new();
         field_tag = '{"r_tl", "g_tl", "b_tl", "r_tr", "g_tr", "b_tr",
                       "r_bl", "g_bl", "b_bl", "r_br", "g_br", "b_br"};
         errors       = 0;
         checked      = 0;
         clamped_low  = 0;
         clamped_high = 0;
      endfunction

      // Floor shift of the 16.16 sum, then saturation to a byte.
      function logic [7:0] clamp_channel(logic [7:0] luma, int chroma_term);
         int sum;
         sum = (int'(luma) * LumaScale + chroma_term) >>> ScaleShift;
         if (sum < 0) begin
            clamped_low++;
            return 8'd0;
         end
         if (sum > 255) begin
            clamped_high++;
            return 8'd255;
         end
         return sum[7:0];
      endfunction

      function yqrgb_pkg::rsp_type convert_quad(yqrgb_pkg::req_type q);
         int          cb_off;
         int          cr_off;
         int          add_r;
         int          add_g;
         int          add_b;
         logic [7:0]  luma [4];
         logic [95:0] flat;
         cb_off = int'(q.cb) - ChromaBias;
         cr_off = int'(q.cr) - ChromaBias;
         add_r  = cr_off * RedCr;
         add_g  = cb_off * GreenCb + cr_off * GreenCr;
         add_b  = cb_off * BlueCb;
         luma   = '{q.y_tl, q.y_tr, q.y_bl, q.y_br};
         for (int p = 0; p < 4; p++) begin
            flat[95 - 24*p -: 8] = clamp_channel(luma[p], add_r);
            flat[87 - 24*p -: 8] = clamp_channel(luma[p], add_g);
            flat[79 - 24*p -: 8] = clamp_channel(luma[p], add_b);
         end
         return yqrgb_pkg::rsp_type'(flat);
      endfunction

      function void note_request(yqrgb_pkg::req_type q);
         expected_rgb.insert(expected_rgb.size(), convert_quad(q));
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= PrintCap) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_response(yqrgb_pkg::rsp_type got);
         logic [95:0] got_flat;
         logic [95:0] want_flat;
         if (expected_rgb.size() == 0) begin
            report_mismatch("response transaction with no quad outstanding");
            return;
         end
         got_flat  = got;
         want_flat = expected_rgb.pop_front();
         checked++;
         for (int f = 0; f < 12; f++) begin
            if (got_flat[95 - 8*f -: 8] !== want_flat[95 - 8*f -: 8]) begin
               report_mismatch($sformatf("response %0d %s: got %0d, expected %0d",
                  checked, field_tag[f], got_flat[95 - 8*f -: 8],
                  want_flat[95 - 8*f -: 8]));
            end
         end
      endtask

      function int unsigned pending();
         return expected_rgb.size();
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_valid  = 1'b0;
   logic               req_ready;
   yqrgb_pkg::req_type req_data   = '0;
   logic               rsp_valid;
   logic               rsp_ready  = 1'b0;
   yqrgb_pkg::rsp_type rsp_data;
   int unsigned        cycle_count = 0;
   int unsigned        quads_sent  = 0;
   int unsigned        stall_left  = 0;

   quad_scoreboard_type board = new();

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   yuv420_quad_to_rgb dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
            cycle_count, board.pending());
         $display("yuv420_quad_to_rgb regression: fail");
         $finish;
      end
   end

   // The receiver cycles through four stall patterns in turn.
   always @(posedge clock) begin
      case (rx_mode_type'((cycle_count / 512) % 4))
         RxFree: begin
            rsp_ready <= 1'b1;
         end
         RxCoin: begin
            rsp_ready <= ($urandom_range(0, 1) != 0);
         end
         RxLongStall: begin
            if (stall_left != 0) begin
               stall_left = stall_left - 1;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               stall_left = $urandom_range(4, 24);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
         default: begin
            rsp_ready <= (cycle_count % 4 == 0);
         end
      endcase
   end

   // Outputs are sampled on the falling edge, where they are settled; a
   // transaction seen here completes at the following rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // Called just after a rising edge; returns just after the accepting edge.
   task automatic send_quad(input yqrgb_pkg::req_type q);
      req_data  <= q;
      req_valid <= 1'b1;
      forever begin
         @(negedge clock);
         if (req_ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      board.note_request(q);
      quads_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   initial begin
      yqrgb_pkg::req_type q;
      int unsigned        sent_random;
      int unsigned        burst_len;
      int unsigned        gap;
      bit                 paused_mid;

      sent_random = 0;
      paused_mid  = 1'b0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes, neutral grey, saturation both ways and floor rounding of
      // small negative chroma terms.
      send_quad(yqrgb_pkg::req_type'{8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128});
      send_quad(yqrgb_pkg::req_type'{8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128});
      send_quad(yqrgb_pkg::req_type'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
      send_quad(yqrgb_pkg::req_type'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
      send_quad(yqrgb_pkg::req_type'{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255});
      send_quad(yqrgb_pkg::req_type'{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0});
      send_quad(yqrgb_pkg::req_type'{8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255});
      send_quad(yqrgb_pkg::req_type'{8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0});
      send_quad(yqrgb_pkg::req_type'{8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd255});
      send_quad(yqrgb_pkg::req_type'{8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0});
      send_quad(yqrgb_pkg::req_type'{8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd127});
      send_quad(yqrgb_pkg::req_type'{8'd0,   8'd0,   8'd0,   8'd0,   8'd127, 8'd128});
      send_quad(yqrgb_pkg::req_type'{8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd129});
      send_quad(yqrgb_pkg::req_type'{8'd1,   8'd2,   8'd254, 8'd253, 8'd129, 8'd129});
      send_quad(yqrgb_pkg::req_type'{8'd16,  8'd235, 8'd16,  8'd235, 8'd16,  8'd240});
      send_quad(yqrgb_pkg::req_type'{8'd255, 8'd254, 8'd1,   8'd0,   8'd127, 8'd129});
      send_quad(yqrgb_pkg::req_type'{8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55});
      send_quad(yqrgb_pkg::req_type'{8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA});
      wait_for_results();

      while (sent_random < RandomQuads) begin
         burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 24);
         for (int k = 0; k < burst_len && sent_random < RandomQuads; k++) begin
            q = yqrgb_pkg::req_type'(48'({$urandom, $urandom}));
            case (quad_mix_type'($urandom_range(0, 3)))
               MixChromaEdge: begin
                  q.cb = $urandom_range(0, 1) ? 8'($urandom_range(240, 255))
                                              : 8'($urandom_range(0, 15));
                  q.cr = $urandom_range(0, 1) ? 8'($urandom_range(240, 255))
                                              : 8'($urandom_range(0, 15));
               end
               MixLumaEdge: begin
                  q.y_tl = $urandom_range(0, 1) ? 8'($urandom_range(248, 255))
                                                : 8'($urandom_range(0, 7));
                  q.y_br = $urandom_range(0, 1) ? 8'($urandom_range(248, 255))
                                                : 8'($urandom_range(0, 7));
               end
               default: begin
               end
            endcase
            send_quad(q);
            sent_random++;
         end
         gap = $urandom_range(0, 6);
         if (!paused_mid && sent_random >= RandomQuads / 2) begin
            paused_mid = 1'b1;
            wait_for_results();
         end else if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      wait_for_results();
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d quads in bursts and gaps; %0d response transactions checked",
         quads_sent, board.checked);
      $display("under four receiver stall patterns, %0d components saturated low, %0d high.",
         board.clamped_low, board.clamped_high);
      if (board.errors == 0) begin
         $display("yuv420_quad_to_rgb regression: pass");
      end else begin
         $display("yuv420_quad_to_rgb regression: fail");
      end
      $finish;
   end

endmodule
